[rtl/ttuv_pkg.sv]
// ----------------------------------------------------------------------------
// ttuv_pkg
// Shared widths, constants and types of the triangle tangent block.
// ----------------------------------------------------------------------------
package ttuv_pkg;

    localparam int C_IN_W   = 32;
    localparam int C_OP_W   = 33;
    localparam int C_PROD_W = 66;
    localparam int C_ACC_W  = 68;
    localparam int C_MAG_W  = 31;
    localparam int C_LEN_W  = 32;
    localparam int C_OUT_W  = 16;
    localparam int C_SAT    = 32767;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic signed [C_OP_W-1:0] f_diff(
        input logic [C_IN_W-1:0] a,
        input logic [C_IN_W-1:0] b
    );
        logic signed [C_OP_W-1:0] ea;
        logic signed [C_OP_W-1:0] eb;
        ea = $signed({a[C_IN_W-1], a});
        eb = $signed({b[C_IN_W-1], b});
        return ea - eb;
    endfunction

endpackage

[rtl/ttuv_if.sv]
// ----------------------------------------------------------------------------
// ttuv_if
// Vertex and tangent channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface ttuv_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttuv_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] tangent_x;
    logic [15:0] tangent_y;
    logic [15:0] tangent_z;
    logic        uv_degenerate;

    modport source (output valid, tangent_x, tangent_y, tangent_z, uv_degenerate,
                    input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, uv_degenerate,
                    output ready);
endinterface

[rtl/triangle_tangent_from_uv_top.sv]
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv_top
// Per-triangle unit tangent from position edges and uv deltas.
// ----------------------------------------------------------------------------
// Vertices arrive one per transfer; the first two corners of a triangle are
// stored as they come. The third corner starts the computation and the
// input stays not ready until its result is in the output register: eight
// products through one shared 33x33 multiplier (a multiply and an accumulate
// state each), a normalizing shift of one or eight bits per cycle, three
// squares, a 32-step square root and three restoring divisions, then the
// load of the output register, which waits while the output is full. A zero
// uv determinant loads its result with uv_degenerate set; an all-zero tangent
// loads a zero result.
// ----------------------------------------------------------------------------
module triangle_tangent_from_uv_top
    import ttuv_pkg::*;
#(
    parameter int TANGENT_FRAC_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttuv_in_if.sink    i_in,
    ttuv_out_if.source o_out
);

    localparam int QW = TANGENT_FRAC_BITS + 1;
    localparam int NW = C_MAG_W + TANGENT_FRAC_BITS + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_ACC    = 4'd2;
    localparam logic [3:0] S_NORM   = 4'd3;
    localparam logic [3:0] S_SQ     = 4'd4;
    localparam logic [3:0] S_SQACC  = 4'd5;
    localparam logic [3:0] S_SQRT   = 4'd6;
    localparam logic [3:0] S_DSTART = 4'd7;
    localparam logic [3:0] S_DWAIT  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]               r_state;
    logic [1:0]               r_cnt;
    logic [2:0]               r_k;
    logic [1:0]               r_j;
    logic [C_IN_W-1:0]        r_a_pos [3];
    logic [C_IN_W-1:0]        r_a_tex [2];
    logic [C_IN_W-1:0]        r_b_pos [3];
    logic [C_IN_W-1:0]        r_b_tex [2];
    logic signed [C_OP_W-1:0] r_e1 [3];
    logic signed [C_OP_W-1:0] r_e2 [3];
    logic signed [C_OP_W-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [C_PROD_W-1:0] r_prod;
    logic signed [C_ACC_W-1:0]  r_acc;
    logic                     r_det_neg;
    logic [C_ACC_W-1:0]       r_mag [3];
    logic                     r_neg [3];
    logic [QW-1:0]            r_q [3];
    logic                     r_zero;
    logic                     r_degen;
    logic [63:0]              r_sn, r_res, r_bit;
    logic                     r_div_start;
    logic                     r_out_valid;
    logic [C_OUT_W-1:0]       r_tx, r_ty, r_tz;
    logic                     r_deg;

    logic                     w_in_acc;
    logic signed [C_OP_W-1:0] w_op_a, w_op_b;
    logic signed [C_OP_W-1:0] w_sel_e;
    logic [C_ACC_W-1:0]       w_sel_m;
    logic [1:0]               w_cj;
    logic signed [C_ACC_W-1:0] w_prod_x, w_acc_n, w_v;
    logic [C_ACC_W-1:0]       w_or;
    logic [64:0]              w_rb;
    logic [NW-1:0]            w_num;
    t_div_stat                w_div_stat;
    logic [QW-1:0]            w_quot;
    logic                     w_out_free;

    function automatic logic [C_OUT_W-1:0] f_tan(
        input logic [QW-1:0] q,
        input logic          neg,
        input logic          zero
    );
        logic [31:0]        q32;
        logic [C_OUT_W-1:0] m;
        q32 = 32'(q);
        m   = (q32 > 32'(C_SAT)) ? C_OUT_W'(C_SAT) : q32[C_OUT_W-1:0];
        if (zero) begin
            return '0;
        end
        return neg ? C_OUT_W'(-m) : m;
    endfunction

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // operand select for the shared multiplier
    assign w_cj = r_k[2:1] - 2'd1;
    always_comb begin
        unique case (w_cj)
            2'd0:    w_sel_e = r_k[0] ? r_e2[0] : r_e1[0];
            2'd1:    w_sel_e = r_k[0] ? r_e2[1] : r_e1[1];
            default: w_sel_e = r_k[0] ? r_e2[2] : r_e1[2];
        endcase
        unique case (r_k[1:0])
            2'd0:    w_sel_m = r_mag[0];
            2'd1:    w_sel_m = r_mag[1];
            default: w_sel_m = r_mag[2];
        endcase
        if (r_state == S_SQ) begin
            w_op_a = $signed({2'b00, w_sel_m[C_MAG_W-1:0]});
            w_op_b = w_op_a;
        end else if (r_k == 3'd0) begin
            w_op_a = r_du1;
            w_op_b = r_dv2;
        end else if (r_k == 3'd1) begin
            w_op_a = r_dv1;
            w_op_b = r_du2;
        end else begin
            w_op_a = r_k[0] ? r_dv1 : r_dv2;
            w_op_b = w_sel_e;
        end
    end

    assign w_prod_x = C_ACC_W'(r_prod);
    always_comb begin
        if (r_state == S_SQACC) begin
            w_acc_n = (r_k == 3'd0) ? w_prod_x : r_acc + w_prod_x;
        end else begin
            w_acc_n = r_k[0] ? r_acc - w_prod_x : w_prod_x;
        end
    end
    assign w_v  = r_det_neg ? -w_acc_n : w_acc_n;
    assign w_or = r_mag[0] | r_mag[1] | r_mag[2];
    assign w_rb = {1'b0, r_res} + {1'b0, r_bit};

    always_comb begin
        unique case (r_j)
            2'd0:    w_num = (NW'(r_mag[0][C_MAG_W-1:0]) << TANGENT_FRAC_BITS);
            2'd1:    w_num = (NW'(r_mag[1][C_MAG_W-1:0]) << TANGENT_FRAC_BITS);
            default: w_num = (NW'(r_mag[2][C_MAG_W-1:0]) << TANGENT_FRAC_BITS);
        endcase
        w_num = w_num + NW'(r_res[C_LEN_W-1:1]);
    end

    ttuv_div #(
        .NW (NW),
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_num),
        .i_den   (r_res[C_LEN_W-1:0]),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 2'd0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_DSTART);
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (r_cnt == 2'd0) begin
                            r_a_pos[0] <= i_in.pos_x;
                            r_a_pos[1] <= i_in.pos_y;
                            r_a_pos[2] <= i_in.pos_z;
                            r_a_tex[0] <= i_in.tex_u;
                            r_a_tex[1] <= i_in.tex_v;
                            r_cnt      <= 2'd1;
                        end else if (r_cnt == 2'd1) begin
                            r_b_pos[0] <= i_in.pos_x;
                            r_b_pos[1] <= i_in.pos_y;
                            r_b_pos[2] <= i_in.pos_z;
                            r_b_tex[0] <= i_in.tex_u;
                            r_b_tex[1] <= i_in.tex_v;
                            r_cnt      <= 2'd2;
                        end else begin
                            r_e1[0] <= f_diff(r_b_pos[0], r_a_pos[0]);
                            r_e1[1] <= f_diff(r_b_pos[1], r_a_pos[1]);
                            r_e1[2] <= f_diff(r_b_pos[2], r_a_pos[2]);
                            r_e2[0] <= f_diff(i_in.pos_x, r_a_pos[0]);
                            r_e2[1] <= f_diff(i_in.pos_y, r_a_pos[1]);
                            r_e2[2] <= f_diff(i_in.pos_z, r_a_pos[2]);
                            r_du1   <= f_diff(r_b_tex[0], r_a_tex[0]);
                            r_dv1   <= f_diff(r_b_tex[1], r_a_tex[1]);
                            r_du2   <= f_diff(i_in.tex_u, r_a_tex[0]);
                            r_dv2   <= f_diff(i_in.tex_v, r_a_tex[1]);
                            r_cnt   <= 2'd0;
                            r_k     <= 3'd0;
                            r_zero  <= 1'b0;
                            r_degen <= 1'b0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= w_op_a * w_op_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= w_acc_n;
                    if (r_k == 3'd1) begin
                        r_det_neg <= w_acc_n[C_ACC_W-1];
                        if (w_acc_n == '0) begin
                            r_zero  <= 1'b1;
                            r_degen <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_MUL;
                        end
                    end else if (r_k[0]) begin
                        r_neg[w_cj] <= w_v[C_ACC_W-1];
                        r_mag[w_cj] <= w_v[C_ACC_W-1] ? $unsigned(-w_v) : $unsigned(w_v);
                        if (r_k == 3'd7) begin
                            r_state <= S_NORM;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_MUL;
                    end
                end
                S_NORM: begin
                    priority if (w_or == '0) begin
                        r_zero  <= 1'b1;
                        r_state <= S_OUT;
                    end else if (w_or[C_ACC_W-1:C_MAG_W+7] != '0) begin
                        r_mag[0] <= r_mag[0] >> 8;
                        r_mag[1] <= r_mag[1] >> 8;
                        r_mag[2] <= r_mag[2] >> 8;
                    end else if (w_or[C_ACC_W-1:C_MAG_W] != '0) begin
                        r_mag[0] <= r_mag[0] >> 1;
                        r_mag[1] <= r_mag[1] >> 1;
                        r_mag[2] <= r_mag[2] >> 1;
                    end else if (w_or[C_MAG_W-1:C_MAG_W-9] == '0) begin
                        r_mag[0] <= r_mag[0] << 8;
                        r_mag[1] <= r_mag[1] << 8;
                        r_mag[2] <= r_mag[2] << 8;
                    end else if (!w_or[C_MAG_W-1]) begin
                        r_mag[0] <= r_mag[0] << 1;
                        r_mag[1] <= r_mag[1] << 1;
                        r_mag[2] <= r_mag[2] << 1;
                    end else begin
                        r_k     <= 3'd0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod  <= w_op_a * w_op_b;
                    r_state <= S_SQACC;
                end
                S_SQACC: begin
                    r_acc <= w_acc_n;
                    if (r_k == 3'd2) begin
                        r_sn    <= w_acc_n[63:0];
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_state <= S_SQRT;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_SQ;
                    end
                end
                S_SQRT: begin
                    if ({1'b0, r_sn} >= w_rb) begin
                        r_sn  <= r_sn - w_rb[63:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_j     <= 2'd0;
                        r_state <= S_DSTART;
                    end
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_stat.done) begin
                        r_q[r_j] <= w_quot;
                        if (r_j == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_tx        <= f_tan(r_q[0], r_neg[0], r_zero);
                        r_ty        <= f_tan(r_q[1], r_neg[1], r_zero);
                        r_tz        <= f_tan(r_q[2], r_neg[2], r_zero);
                        r_deg       <= r_degen;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.tangent_x     = r_tx;
    assign o_out.tangent_y     = r_ty;
    assign o_out.tangent_z     = r_tz;
    assign o_out.uv_degenerate = r_deg;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("corner count out of range");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> !w_div_stat.busy)
        else $error("divider restarted while busy");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> r_state == S_DWAIT)
        else $error("divider result outside wait state");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_out.ready) |=> r_state == S_OUT)
        else $error("result dropped into a full output register");

endmodule

[rtl/ttuv_div.sv]
// ----------------------------------------------------------------------------
// ttuv_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttuv_div
    import ttuv_pkg::*;
#(
    parameter int NW = 46,
    parameter int QW = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NW-1:0]      i_num,
    input  logic [C_LEN_W-1:0] i_den,
    output t_div_stat          o_stat,
    output logic [QW-1:0]      o_quot
);

    localparam int CW = $clog2(QW + 1);

    logic [C_LEN_W-1:0] r_rem;
    logic [QW-1:0]      r_low;
    logic [QW-1:0]      r_quot;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [C_LEN_W:0]   w_trial;
    logic               w_ge;

    assign w_trial = {r_rem, r_low[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= C_LEN_W'(i_num[NW-1:QW]);
                r_low  <= i_num[QW-1:0];
                r_cnt  <= CW'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? C_LEN_W'(w_trial - {1'b0, i_den}) : w_trial[C_LEN_W-1:0];
                r_quot <= {r_quot[QW-2:0], w_ge};
                r_low  <= {r_low[QW-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of triangle_tangent_from_uv_top. Vertex triples go in through a
// bursty valid/ready driver; a bit-exact tangent predictor forms the expected
// result of every third corner, and a monitor checks each output transfer
// against the oldest pending tangent while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
    import ttuv_pkg::*;

    localparam int TFB        = 14;
    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_WAIT  = 300;

    typedef struct packed {
        logic        hold;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] tu;
        logic [31:0] tv;
    } vertex_t;

    typedef struct packed {
        logic [15:0] tx;
        logic [15:0] ty;
        logic [15:0] tz;
        logic        degen;
    } tangent_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ttuv_in_if  vtx_ch ();
    ttuv_out_if tan_ch ();

    triangle_tangent_from_uv_top #(.TANGENT_FRAC_BITS(TFB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (vtx_ch.sink),
        .o_out   (tan_ch.source)
    );

    always #1 i_clk = ~i_clk;

    vertex_t  vertex_q[$];
    tangent_t tangent_q[$];
    vertex_t  corner_a;
    vertex_t  corner_b;
    logic [1:0] corner_cnt = '0;
    bit  stim_done = 1'b0;
    bit  in_xfer = 1'b0;
    int  err_cnt = 0;
    int  tri_cnt = 0;
    int  degen_cnt = 0;
    int  res_cnt = 0;
    int  idle_cnt = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_mode = 0;
    int  mode_left = 0;

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic tangent_t compute_tangent(input vertex_t a, input vertex_t b,
                                                 input vertex_t c);
        logic signed [127:0] pa[3];
        logic signed [127:0] pb[3];
        logic signed [127:0] pc[3];
        logic signed [127:0] du1, dv1, du2, dv2, det;
        logic signed [127:0] cmp[3];
        logic [127:0] shifted;
        logic [63:0]  mag[3];
        logic [63:0]  sum, len, q;
        logic         neg[3];
        logic [15:0]  comp[3];
        int           maxbl;
        tangent_t     r;
        pa[0] = $signed(a.px); pa[1] = $signed(a.py); pa[2] = $signed(a.pz);
        pb[0] = $signed(b.px); pb[1] = $signed(b.py); pb[2] = $signed(b.pz);
        pc[0] = $signed(c.px); pc[1] = $signed(c.py); pc[2] = $signed(c.pz);
        du1 = 128'($signed(b.tu)) - 128'($signed(a.tu));
        dv1 = 128'($signed(b.tv)) - 128'($signed(a.tv));
        du2 = 128'($signed(c.tu)) - 128'($signed(a.tu));
        dv2 = 128'($signed(c.tv)) - 128'($signed(a.tv));
        det = du1 * dv2 - dv1 * du2;
        r = '0;
        if (det == 0) begin
            r.degen = 1'b1;
            return r;
        end
        maxbl = 0;
        for (int i = 0; i < 3; i++) begin
            cmp[i] = dv2 * (pb[i] - pa[i]) - dv1 * (pc[i] - pa[i]);
            if (det < 0) cmp[i] = -cmp[i];
            neg[i] = cmp[i] < 0;
            if (neg[i]) cmp[i] = -cmp[i];
            for (int k = 0; k < 128; k++) begin
                if (cmp[i][k] && k + 1 > maxbl) maxbl = k + 1;
            end
        end
        if (maxbl == 0) return r;
        for (int i = 0; i < 3; i++) begin
            if (maxbl > 31) shifted = cmp[i] >> (maxbl - 31);
            else shifted = cmp[i] << (31 - maxbl);
            mag[i] = shifted[63:0];
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = isqrt64(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << TFB) + (len >> 1)) / len;
            if (q > 64'(C_SAT)) q = 64'(C_SAT);
            comp[i] = neg[i] ? 16'(-q) : q[15:0];
        end
        r.tx = comp[0];
        r.ty = comp[1];
        r.tz = comp[2];
        return r;
    endfunction

    function automatic vertex_t make_vertex(input logic [31:0] px, py, pz, tu, tv);
        vertex_t v;
        v.hold = 1'b0;
        v.px = px; v.py = py; v.pz = pz; v.tu = tu; v.tv = tv;
        return v;
    endfunction

    function automatic logic [31:0] near(input logic [31:0] base, input int span);
        return base + 32'($signed($urandom_range(2 * span, 0)) - span);
    endfunction

    task automatic add_triangle(input vertex_t a, input vertex_t b, input vertex_t c);
        vertex_q = {vertex_q, a};
        vertex_q = {vertex_q, b};
        vertex_q = {vertex_q, c};
    endtask

    task automatic add_random_triangle();
        vertex_t v[3];
        logic [31:0] base[5];
        int kind;
        int span;
        kind = $urandom_range(9);
        span = (kind < 4) ? 16 : 1 << $urandom_range(24, 4);
        for (int j = 0; j < 5; j++) base[j] = $urandom;
        for (int i = 0; i < 3; i++) begin
            if (kind == 9) begin
                v[i] = make_vertex($urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                v[i] = make_vertex(near(base[0], span), near(base[1], span),
                                   near(base[2], span), near(base[3], span),
                                   near(base[4], span));
            end
        end
        if (kind == 8) begin
            v[2].tu = v[0].tu;
            v[2].tv = v[0].tv;
        end else if (kind == 7) begin
            v[1].px = v[0].px; v[1].py = v[0].py; v[1].pz = v[0].pz;
            v[2].px = v[0].px; v[2].py = v[0].py; v[2].pz = v[0].pz;
        end
        add_triangle(v[0], v[1], v[2]);
    endtask

    initial begin
        vertex_t z, mx, mn, t;
        z  = make_vertex(0, 0, 0, 0, 0);
        mx = make_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff, 32'h7fffffff);
        mn = make_vertex(32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h80000000);
        add_triangle(z, make_vertex(32'h10000, 0, 0, 32'h10000, 0),
                     make_vertex(0, 32'h10000, 0, 0, 32'h10000));
        add_triangle(mn, make_vertex(32'h7fffffff, 32'h80000000, 32'h80000000,
                                     32'h7fffffff, 32'h80000000),
                     make_vertex(32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                 32'h80000000, 32'h7fffffff));
        add_triangle(mx, mn, make_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                         32'h80000000, 32'h7fffffff));
        add_triangle(z, make_vertex(5, 6, 7, 3, 3), make_vertex(1, 2, 3, 6, 6));
        add_triangle(z, make_vertex(0, 0, 0, 32'h10000, 0),
                     make_vertex(0, 0, 0, 0, 32'h10000));
        add_triangle(z, make_vertex(1, 0, 0, 0, 1), make_vertex(0, 1, 0, 1, 0));
        t = make_vertex(32'h12345678, 32'hdeadbeef, 32'h0, 32'h1, 32'hffffffff);
        t.hold = 1'b1;
        add_triangle(t, mn, make_vertex(32'h7fffffff, 0, 32'h80000000, 0, 32'h7fffffff));
        for (int n = 0; n < 643; n++) begin
            add_random_triangle();
            if (n % 200 == 100) vertex_q[vertex_q.size() - 3].hold = 1'b1;
        end
        stim_done = 1'b1;
    end

    initial begin
        vtx_ch.valid = 1'b0;
        vtx_ch.pos_x = '0;
        vtx_ch.pos_y = '0;
        vtx_ch.pos_z = '0;
        vtx_ch.tex_u = '0;
        vtx_ch.tex_v = '0;
        tan_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // driver and receiver stall pattern, both on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_xfer) begin
                void'(vertex_q.pop_front());
            end
            if (!vtx_ch.valid || in_xfer) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    vtx_ch.valid <= 1'b0;
                end else if (burst_left == 0) begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(20);
                    vtx_ch.valid <= 1'b0;
                end else if (vertex_q.size() > 0 &&
                             !(vertex_q[0].hold && tangent_q.size() != 0)) begin
                    vtx_ch.valid <= 1'b1;
                    vtx_ch.pos_x <= vertex_q[0].px;
                    vtx_ch.pos_y <= vertex_q[0].py;
                    vtx_ch.pos_z <= vertex_q[0].pz;
                    vtx_ch.tex_u <= vertex_q[0].tu;
                    vtx_ch.tex_v <= vertex_q[0].tv;
                    burst_left <= burst_left - 1;
                end else begin
                    vtx_ch.valid <= 1'b0;
                end
            end
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(3);
                mode_left <= $urandom_range(200, 20);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: begin
                    tan_ch.ready <= 1'b1;
                end
                1: begin
                    tan_ch.ready <= $urandom_range(1);
                end
                2: begin
                    tan_ch.ready <= ($urandom_range(7) == 0);
                end
                default: begin
                    tan_ch.ready <= (mode_left % 16) < 4;
                end
            endcase
        end
    end

    // monitor: predict on vertex transfer, check on tangent transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_xfer <= vtx_ch.valid && vtx_ch.ready;
            if ((vtx_ch.valid && vtx_ch.ready) || (tan_ch.valid && tan_ch.ready)) begin
                idle_cnt <= 0;
            end else begin
                idle_cnt <= idle_cnt + 1;
            end
            if (vtx_ch.valid && vtx_ch.ready) begin
                vertex_t v;
                tangent_t e;
                v = make_vertex(vtx_ch.pos_x, vtx_ch.pos_y, vtx_ch.pos_z,
                                vtx_ch.tex_u, vtx_ch.tex_v);
                case (corner_cnt)
                    2'd0: begin
                        corner_a <= v;
                        corner_cnt <= 2'd1;
                    end
                    2'd1: begin
                        corner_b <= v;
                        corner_cnt <= 2'd2;
                    end
                    default: begin
                        e = compute_tangent(corner_a, corner_b, v);
                        tangent_q = {tangent_q, e};
                        tri_cnt <= tri_cnt + 1;
                        if (e.degen) degen_cnt <= degen_cnt + 1;
                        corner_cnt <= 2'd0;
                    end
                endcase
            end
            if (tan_ch.valid && tan_ch.ready) begin
                tangent_t got, want;
                res_cnt <= res_cnt + 1;
                got.tx = tan_ch.tangent_x;
                got.ty = tan_ch.tangent_y;
                got.tz = tan_ch.tangent_z;
                got.degen = tan_ch.uv_degenerate;
                if (tangent_q.size() == 0) begin
                    $display("%0t: unexpected tangent %h", $time, got);
                    err_cnt <= err_cnt + 1;
                end else begin
                    want = tangent_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: tangent mismatch expected x=%h y=%h z=%h d=%b",
                                 $time, want.tx, want.ty, want.tz, want.degen);
                        $display("%0t:                  actual   x=%h y=%h z=%h d=%b",
                                 $time, got.tx, got.ty, got.tz, got.degen);
                        err_cnt <= err_cnt + 1;
                    end
                end
            end
        end
    end

    initial begin
        wait (i_rst_n);
        fork
            begin
                wait (stim_done && vertex_q.size() == 0 && tangent_q.size() == 0);
                repeat (TAIL_WAIT) @(posedge i_clk);
                @(negedge i_clk);
                $display("Triangles sent: %0d, degenerate: %0d, tangents checked: %0d",
                         tri_cnt, degen_cnt, res_cnt);
                if (err_cnt == 0 && tangent_q.size() == 0) begin
                    $display("triangle_tangent_from_uv_top verification clean");
                end else begin
                    $display("triangle_tangent_from_uv_top verification failed");
                end
                $finish;
            end
            begin
                wait (idle_cnt >= IDLE_LIMIT);
                $display("%0t: watchdog expired, %0d tangents pending",
                         $time, tangent_q.size());
                $display("triangle_tangent_from_uv_top verification failed");
                $finish;
            end
        join
    end

endmodule

[filelist.f]
rtl/ttuv_pkg.sv
rtl/ttuv_if.sv
rtl/ttuv_div.sv
rtl/triangle_tangent_from_uv_top.sv
dv/tb.sv
